// ----- hdl/brn_pkg.sv -----
// Shared types, codes and symbol tables for the binary to Roman numeral converter.
`default_nettype none

package brn_pkg;

    localparam int ValueWidth = 12;
    localparam int CharWidth  = 7;
    localparam int MaxValue   = 3999;

    // ASCII codes of the Roman symbols.
    localparam logic [CharWidth-1:0] CHAR_I    = 7'h49;
    localparam logic [CharWidth-1:0] CHAR_V    = 7'h56;
    localparam logic [CharWidth-1:0] CHAR_X    = 7'h58;
    localparam logic [CharWidth-1:0] CHAR_L    = 7'h4C;
    localparam logic [CharWidth-1:0] CHAR_C    = 7'h43;
    localparam logic [CharWidth-1:0] CHAR_D    = 7'h44;
    localparam logic [CharWidth-1:0] CHAR_M    = 7'h4D;
    localparam logic [CharWidth-1:0] CHAR_NONE = 7'h00;

    // Decimal places, most significant first.
    localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
    localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
    localparam logic [1:0] PLACE_TENS      = 2'd2;
    localparam logic [1:0] PLACE_ONES      = 2'd3;

    typedef struct packed {
        logic       load;      // take a new value into the remainder register
        logic       emit;      // load the output register with the current character
        logic       emit_err;  // load the output register with the error result
        logic       advance;   // step the remainder past the current place
        logic [1:0] place;
        logic [1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic       in_range;  // value on the input port is 1 to 3999
        logic [2:0] pat_len;   // characters in the current digit's pattern
        logic       is_last;   // current character ends the numeral
    } t_sts;

    // k times the weight of a place, wide enough for 9 * 1000.
    function automatic logic [13:0] place_mul(input logic [1:0] place, input logic [3:0] k);
        logic [13:0] w;
        unique case (place)
            PLACE_THOUSANDS: w = 14'd1000;
            PLACE_HUNDREDS:  w = 14'd100;
            PLACE_TENS:      w = 14'd10;
            PLACE_ONES:      w = 14'd1;
            default:         w = 14'd1;
        endcase
        return 14'(w * {10'd0, k});
    endfunction

    function automatic logic [CharWidth-1:0] sym_one(input logic [1:0] place);
        logic [CharWidth-1:0] c;
        unique case (place)
            PLACE_THOUSANDS: c = CHAR_M;
            PLACE_HUNDREDS:  c = CHAR_C;
            PLACE_TENS:      c = CHAR_X;
            default:         c = CHAR_I;
        endcase
        return c;
    endfunction

    function automatic logic [CharWidth-1:0] sym_five(input logic [1:0] place);
        logic [CharWidth-1:0] c;
        unique case (place)
            PLACE_HUNDREDS: c = CHAR_D;
            PLACE_TENS:     c = CHAR_L;
            PLACE_ONES:     c = CHAR_V;
            default:        c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CharWidth-1:0] sym_ten(input logic [1:0] place);
        logic [CharWidth-1:0] c;
        unique case (place)
            PLACE_HUNDREDS: c = CHAR_M;
            PLACE_TENS:     c = CHAR_C;
            PLACE_ONES:     c = CHAR_X;
            default:        c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] pat_len(input logic [3:0] d);
        logic [2:0] n;
        if (d == 4'd4 || d == 4'd9) begin
            n = 3'd2;
        end else if (d >= 4'd5) begin
            n = 3'(d - 4'd4);
        end else begin
            n = d[2:0];
        end
        return n;
    endfunction

    function automatic logic [CharWidth-1:0] pat_char(input logic [1:0] place,
                                                      input logic [3:0] d,
                                                      input logic [1:0] pos);
        logic [CharWidth-1:0] c;
        if (d == 4'd4) begin
            c = (pos == 2'd0) ? sym_one(place) : sym_five(place);
        end else if (d == 4'd9) begin
            c = (pos == 2'd0) ? sym_one(place) : sym_ten(place);
        end else if (d >= 4'd5) begin
            c = (pos == 2'd0) ? sym_five(place) : sym_one(place);
        end else begin
            c = sym_one(place);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/binary_to_roman_numeral.sv -----
// Top level of the binary to Roman numeral converter: controller plus datapath.
`default_nettype none

// Usage:
// The input channel (i_valid, o_stall, i_value) takes one 12-bit number per
// transaction. The output channel (o_valid, i_stall, o_char_code, o_is_last,
// o_out_of_range) returns the numeral as ASCII characters, most significant
// first, one character per transaction; o_is_last marks the final one.
// A value of 0 or above 3999 gives a single transaction with char_code 0,
// is_last 1 and out_of_range 1.
// One number is converted at a time: o_stall is high from the accepting edge
// until the last character has been written into the output register. After
// leaving idle, the controller writes one character or skips one zero digit
// per step, and waits to write while a stalled character fills the output
// register. The first character is written once any leading zero places are
// skipped, and it reaches o_valid from the output register.
// The output register holds a stalled transaction unchanged; while it waits
// the controller holds its position but still skips zero digits. The next number
// may be taken while the last character of the previous one still waits there.
// Synchronous reset clears the controller to idle and drops o_valid.

module binary_to_roman_numeral (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [brn_pkg::ValueWidth-1:0]     i_value,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [brn_pkg::CharWidth-1:0]      o_char_code,
    output logic                               o_is_last,
    output logic                               o_out_of_range
);
    import brn_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller walks the places and the positions within each pattern.
    brn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    // The datapath keeps the remainder, finds each digit and holds the output payload.
    brn_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_sts          (sts),
        .o_char_code    (o_char_code),
        .o_is_last      (o_is_last),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

// ----- hdl/brn_dp.sv -----
// Datapath: remainder register, digit extraction per place and the output payload register.
`default_nettype none

module brn_dp (
    input  wire                                i_clk,
    input  brn_pkg::t_cmd                      i_cmd,
    input  wire  [brn_pkg::ValueWidth-1:0]     i_value,
    output brn_pkg::t_sts                      o_sts,
    output logic [brn_pkg::CharWidth-1:0]      o_char_code,
    output logic                               o_is_last,
    output logic                               o_out_of_range
);
    import brn_pkg::*;

    logic [ValueWidth-1:0] r_rem;
    logic [ValueWidth-1:0] n_rem;
    logic [ValueWidth-1:0] rem_next;
    logic [3:0]            digit;
    logic [13:0]           sub;
    logic [2:0]            len;
    logic [CharWidth-1:0]  cur_char;
    logic                  cur_last;

    // The digit of the current place is the largest k with k * weight <= remainder.
    // All nine compares run side by side.
    always_comb begin
        digit = 4'd0;
        sub   = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r_rem} >= place_mul(i_cmd.place, 4'(k))) begin
                digit = 4'(k);
                sub   = place_mul(i_cmd.place, 4'(k));
            end
        end
    end

    assign rem_next = r_rem - sub[ValueWidth-1:0];
    assign len      = pat_len(digit);
    assign cur_char = pat_char(i_cmd.place, digit, i_cmd.pos);
    assign cur_last = ({1'b0, i_cmd.pos} == 3'(len - 3'd1)) && (rem_next == '0);

    assign o_sts.in_range = (i_value != '0) && ({20'd0, i_value} <= 32'(MaxValue));
    assign o_sts.pat_len  = len;
    assign o_sts.is_last  = cur_last;

    always_comb begin
        n_rem = r_rem;
        if (i_cmd.load) begin
            n_rem = i_value;
        end else if (i_cmd.advance) begin
            n_rem = rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (i_cmd.emit) begin
            o_char_code    <= cur_char;
            o_is_last      <= cur_last;
            o_out_of_range <= 1'b0;
        end else if (i_cmd.emit_err) begin
            o_char_code    <= CHAR_NONE;
            o_is_last      <= 1'b1;
            o_out_of_range <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/brn_ctrl.sv -----
// Controller: sequences places and pattern positions and owns both handshakes.
`default_nettype none

module brn_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_out_stall,
    input  brn_pkg::t_sts i_sts,
    output brn_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import brn_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_place, n_place;
    logic [1:0] r_pos,   n_pos;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;
    logic       in_take;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_place        = r_place;
        n_pos          = r_pos;
        o_cmd.load     = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.emit_err = 1'b0;
        o_cmd.advance  = 1'b0;
        o_cmd.place    = r_place;
        o_cmd.pos      = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    o_cmd.load = 1'b1;
                    n_place    = PLACE_THOUSANDS;
                    n_pos      = 2'd0;
                    n_state    = i_sts.in_range ? ST_RUN : ST_ERR;
                end
            end
            ST_RUN: begin
                if (i_sts.pat_len == 3'd0) begin
                    // A zero digit emits nothing; move straight to the next place.
                    o_cmd.advance = 1'b1;
                    n_place       = r_place + 2'd1;
                    n_pos         = 2'd0;
                end else if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.is_last) begin
                        n_state = ST_IDLE;
                    end else if ({1'b0, r_pos} == 3'(i_sts.pat_len - 3'd1)) begin
                        o_cmd.advance = 1'b1;
                        n_place       = r_place + 2'd1;
                        n_pos         = 2'd0;
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit || o_cmd.emit_err) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_place     <= PLACE_THOUSANDS;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_place     <= n_place;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // A character is never written over a result that is still waiting.
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.emit_err) |-> slot_free)
        else $error("output register overwritten while stalled");

    // The final character of a numeral returns the controller to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.is_last) |=> (r_state == ST_IDLE))
        else $error("controller did not go idle after the last character");

    // A place with a zero digit can never be where the numeral ends.
    a_zero_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && i_sts.pat_len == 3'd0) |=> (r_state == ST_RUN))
        else $error("conversion ended on a zero digit");

    // The pattern position stays inside the current digit's pattern.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && i_sts.pat_len != 3'd0) |-> ({1'b0, r_pos} < i_sts.pat_len))
        else $error("pattern position outside the digit pattern");

endmodule

`default_nettype wire

// ----- dv/binary_to_roman_numeral_tb.sv -----
// Self-checking testbench for the binary to Roman numeral converter.
`timescale 1ns / 1ps

module binary_to_roman_numeral_tb;

    import brn_pkg::*;

    // One character of a numeral as the block should return it.
    typedef struct packed {
        logic [CharWidth-1:0] code;
        logic                 last;
        logic                 err;
    } t_roman_char;

    localparam int DirectedCount = 22;
    localparam int RandomCount   = 198;
    localparam int LongHoldOff   = 300;
    localparam int DrainCycles   = 40;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [ValueWidth-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [CharWidth-1:0]  o_char_code;
    logic                  o_is_last;
    logic                  o_out_of_range;

    // Numbers still to be offered, and characters still owed by the block.
    logic [ValueWidth-1:0] number_q[$];
    t_roman_char           numeral_chars_q[$];

    int failures        = 0;
    int numbers_taken   = 0;
    int range_errors    = 0;
    int chars_checked   = 0;
    int longest_numeral = 0;
    int hold_off_left   = 0;
    int send_wait       = 0;
    int recv_wait       = 0;

    binary_to_roman_numeral dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_code    (o_char_code),
        .o_is_last      (o_is_last),
        .o_out_of_range (o_out_of_range)
    );

    // The clock runs with an 8 ns period, half high and half low.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Works out the characters of one number and appends them to the queue of
    // characters the block owes. Each decimal place contributes its one, five
    // and ten symbols, with the subtractive pairs for the digits 4 and 9.
    function automatic void expand_numeral(input logic [ValueWidth-1:0] number);
        logic [CharWidth-1:0] chars[$];
        logic [CharWidth-1:0] one_sym;
        logic [CharWidth-1:0] five_sym;
        logic [CharWidth-1:0] ten_sym;
        t_roman_char          entry;
        int unsigned          weight;
        int unsigned          digit;
        logic [1:0]           place;
        int                   p;
        int                   k;

        if (number == 0 || number > MaxValue) begin
            entry = '{code: CHAR_NONE, last: 1'b1, err: 1'b1};
            numeral_chars_q.push_back(entry);
            range_errors++;
            return;
        end

        for (p = 0; p < 4; p++) begin
            place = p[1:0];
            case (place)
                PLACE_THOUSANDS: begin
                    weight = 1000; one_sym = CHAR_M; five_sym = CHAR_NONE; ten_sym = CHAR_NONE;
                end
                PLACE_HUNDREDS: begin
                    weight = 100; one_sym = CHAR_C; five_sym = CHAR_D; ten_sym = CHAR_M;
                end
                PLACE_TENS: begin
                    weight = 10; one_sym = CHAR_X; five_sym = CHAR_L; ten_sym = CHAR_C;
                end
                default: begin
                    weight = 1; one_sym = CHAR_I; five_sym = CHAR_V; ten_sym = CHAR_X;
                end
            endcase
            digit = (number / weight) % 10;
            if (digit == 4) begin
                chars.push_back(one_sym);
                chars.push_back(five_sym);
            end else if (digit == 9) begin
                chars.push_back(one_sym);
                chars.push_back(ten_sym);
            end else begin
                if (digit >= 5) begin
                    chars.push_back(five_sym);
                    digit -= 5;
                end
                for (k = 0; k < digit; k++) chars.push_back(one_sym);
            end
        end

        for (k = 0; k < chars.size(); k++) begin
            entry = '{code: chars[k], last: (k == chars.size() - 1), err: 1'b0};
            numeral_chars_q.push_back(entry);
        end
        if (chars.size() > longest_numeral) longest_numeral = chars.size();
    endfunction

    // Sender. Each number waits a randomly drawn delay after the previous
    // transaction, except in calm stretches where numbers follow back to back.
    // The valid is computed first and assigned once per edge, so in a calm
    // stretch it stays high between two consecutive numbers.
    always @(posedge i_clk) begin
        logic accepted;
        logic offer;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            accepted = i_valid && !o_stall;
            if (accepted) begin
                expand_numeral(i_value);
                numbers_taken++;
                send_wait = ((numbers_taken / 32) % 3 == 1) ? 0 : $urandom_range(0, 3);
            end
            offer = i_valid && !accepted;
            if (!offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (number_q.size() > 0) begin
                    i_value <= number_q.pop_front();
                    offer = 1'b1;
                end
            end
            i_valid <= offer;
        end
    end

    // Receiver and checker. Every transaction is compared with the oldest
    // character owed. After the sixtieth character the receiver holds off for
    // a long stretch so that the output register fills and the block stalls
    // its input while the sender keeps offering.
    always @(posedge i_clk) begin
        t_roman_char want;
        logic        hold;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (numeral_chars_q.size() == 0) begin
                    $error("unexpected character: char_code %0h is_last %0b out_of_range %0b",
                           o_char_code, o_is_last, o_out_of_range);
                    failures++;
                end else begin
                    want = numeral_chars_q.pop_front();
                    if (o_char_code !== want.code) begin
                        $error("char_code: expected %0h, got %0h", want.code, o_char_code);
                        failures++;
                    end
                    if (o_is_last !== want.last) begin
                        $error("is_last: expected %0b, got %0b", want.last, o_is_last);
                        failures++;
                    end
                    if (o_out_of_range !== want.err) begin
                        $error("out_of_range: expected %0b, got %0b", want.err, o_out_of_range);
                        failures++;
                    end
                end
                chars_checked++;
                recv_wait = ((chars_checked / 64) % 3 == 1) ? 0 : $urandom_range(0, 3);
                if (chars_checked == 60) hold_off_left = LongHoldOff;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                hold = 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                hold = 1'b1;
            end else begin
                hold = 1'b0;
            end
            i_stall <= hold;
        end
    end

    // Numbers to convert: the range edges, the out-of-range values, the longest
    // numeral, the subtractive forms at every place, then random numbers that
    // are mostly valid with some out-of-range and long ones mixed in.
    initial begin
        static logic [ValueWidth-1:0] directed [DirectedCount] = '{
            12'd0, 12'd4000, 12'd4095, 12'd1, 12'd3999, 12'd3888, 12'd4, 12'd9,
            12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd3000, 12'd2468,
            12'd1357, 12'd1066, 12'd3449, 12'd1904, 12'd505, 12'd2048, 12'd3333
        };
        int i;
        int pick;

        foreach (directed[i]) number_q.push_back(directed[i]);
        for (i = 0; i < RandomCount; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                number_q.push_back($urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(4000, 4095)));
            end else if (pick == 1) begin
                // Digits of 3, 7 and 8 give long patterns, and 8 the longest.
                number_q.push_back(12'(1000 * $urandom_range(1, 3) + 100 * $urandom_range(7, 8)
                                       + 10 * $urandom_range(7, 8) + $urandom_range(7, 8)));
            end else begin
                number_q.push_back(12'($urandom_range(1, MaxValue)));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every number has been taken and every character returned,
        // then give the block time to show any stray output.
        while (number_q.size() > 0 || i_valid) @(negedge i_clk);
        while (numeral_chars_q.size() > 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        $display("Converted %0d numbers (%0d out of range) into %0d checked characters.",
                 numbers_taken, range_errors, chars_checked);
        $display("Longest numeral %0d characters; one receiver hold-off of %0d cycles.",
                 longest_numeral, LongHoldOff);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
